>>> hdl/ray_box_slab_intersect_assert.svh
// assertion macros for the ray/box slab intersect block
// used by the top level; no other dependencies
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RBSI_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define RBSI_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define RBSI_ASSERT_SAME(lbl, ck, rn, ante, cons, msg)
`define RBSI_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

>>> hdl/rbsi_pkg.sv
// shared types and constants for the ray/box slab intersect block
// no dependencies
`timescale 1ns / 1ps
package rbsi_pkg;
	localparam int REG_W = 31;
	localparam int QUO_W = 31;
	localparam int DIST_W = REG_W + 1;
	localparam int OUT_TDATA_W = 40;

	localparam logic CFG_EPS = 1'b0;
	localparam logic CFG_LIM = 1'b1;

	typedef struct packed {
		logic       vld;
		logic       pmiss;
		logic [2:0] para;
		logic [5:0] neg;
	} side_t;
endpackage

>>> hdl/rbsi_slab_div.sv
// pipelined restoring divider for one slab distance, one quotient bit per stage
// depends on rbsi_pkg
`timescale 1ns / 1ps
module rbsi_slab_div import rbsi_pkg::*; #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic             clk,
	input  logic             en,
	input  logic [W:0]       num_mag,
	input  logic [W-1:0]     den,
	output logic [QUO_W-1:0] quo,
	output logic             ovf
);
	localparam int TW  = W + 1 + F;
	localparam int NPW = TW + QUO_W;

	logic [NPW-1:0]   n_ext;
	logic [TW-1:0]    top;
	logic             ovf0;

	logic [W-1:0]     rem_s [0:QUO_W];
	logic [QUO_W-1:0] low_s [0:QUO_W];
	logic [QUO_W-1:0] quo_s [0:QUO_W];
	logic [W-1:0]     den_s [0:QUO_W];
	logic             ovf_s [0:QUO_W];

	assign n_ext = {{QUO_W{1'b0}}, num_mag, {F{1'b0}}};
	assign top   = n_ext[NPW-1:QUO_W];
	assign ovf0  = top >= {{(F+1){1'b0}}, den};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= top[W-1:0];
			low_s[0] <= n_ext[QUO_W-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			ovf_s[0] <= ovf0;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [W:0] trial;
		logic [W:0] diff;
		logic       ge;
		assign trial = {rem_s[k], low_s[k][QUO_W-1]};
		assign diff  = trial - {1'b0, den_s[k]};
		assign ge    = trial >= {1'b0, den_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[W-1:0] : trial[W-1:0];
				low_s[k+1] <= {low_s[k][QUO_W-2:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][QUO_W-2:0], ge};
				den_s[k+1] <= den_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign quo = quo_s[QUO_W];
	assign ovf = ovf_s[QUO_W];
endmodule

>>> hdl/ray_box_slab_intersect.sv
// channel  | dir | payload
// s_axis   | in  | ray origin, direction, box corners, COORD_WIDTH each
// m_axis   | out | hit, hit_distance, origin_inside
// cfg      | in  | register index and write data
// one ray/box test enters per cycle unless a result waits untaken at the output
// the pipeline runs through six pipelined dividers, one quotient bit per stage
// the whole pipeline advances together and holds while a result waits untaken
// reset clears the valid bits and sets epsilon 0, limit 0x7fffffff
// top level of the ray/box slab intersect block
// depends on rbsi_pkg, rbsi_slab_div and ray_box_slab_intersect_assert.svh
`timescale 1ns / 1ps
`include "ray_box_slab_intersect_assert.svh"
module ray_box_slab_intersect import rbsi_pkg::*; #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// origin_x/y/z, dir_x/y/z, box_min_x/y/z, box_max_x/y/z, zero pad
	input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// hit, hit_distance, origin_inside, zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [REG_W-1:0]       cfg_data
);
	localparam int W = COORD_WIDTH;
	localparam int DIV_LAT = QUO_W + 1;

	logic [REG_W-1:0] eps_q;
	logic [REG_W-1:0] lim_q;
	logic             en;

	// config
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= '0;
			lim_q <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_EPS: eps_q <= cfg_data;
				CFG_LIM: lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: slab offsets and parallel test
	logic signed [W:0]   dlo_s1 [3];
	logic signed [W:0]   dhi_s1 [3];
	logic [W-1:0]        dmag_s1 [3];
	logic [2:0]          dneg_s1;
	logic [2:0]          para_s1;
	logic                pmiss_s1;
	logic                vld_s1;

	logic signed [W-1:0] org [3];
	logic signed [W-1:0] dir [3];
	logic signed [W-1:0] bmin [3];
	logic signed [W-1:0] bmax [3];
	logic [W-1:0]        dmag [3];
	logic [2:0]          para;
	logic [2:0]          outside;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			org[a]  = s_axis_tdata[a*W +: W];
			dir[a]  = s_axis_tdata[(3+a)*W +: W];
			bmin[a] = s_axis_tdata[(6+a)*W +: W];
			bmax[a] = s_axis_tdata[(9+a)*W +: W];
			dmag[a] = dir[a][W-1] ? W'(-dir[a]) : W'(dir[a]);
			para[a] = {{REG_W{1'b0}}, dmag[a]} <= {{W{1'b0}}, eps_q};
			outside[a] = (org[a] < bmin[a]) || (org[a] > bmax[a]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				dlo_s1[a]  <= (W+1)'(bmin[a]) - (W+1)'(org[a]);
				dhi_s1[a]  <= (W+1)'(bmax[a]) - (W+1)'(org[a]);
				dmag_s1[a] <= dmag[a];
				dneg_s1[a] <= dir[a][W-1];
			end
			para_s1  <= para;
			pmiss_s1 <= |(para & outside);
		end
	end

	// stage 2: dividers, sideband delayed alongside
	logic [QUO_W-1:0] quo [6];
	logic [5:0]       ovf;
	logic [5:0]       neg_l;
	side_t            side_in;
	side_t            side_s2 [DIV_LAT];

	for (genvar l = 0; l < 6; l++) begin : g_div
		logic signed [W:0] num;
		logic [W:0]        num_mag;
		assign num     = (l % 2 == 0) ? dlo_s1[l/2] : dhi_s1[l/2];
		assign num_mag = num[W] ? (W+1)'(-num) : (W+1)'(num);
		rbsi_slab_div #(.W(W), .F(FRAC_BITS)) u_div (
			.clk     (clk),
			.en      (en),
			.num_mag (num_mag),
			.den     (dmag_s1[l/2]),
			.quo     (quo[l]),
			.ovf     (ovf[l])
		);
		assign neg_l[l] = num[W] ^ dneg_s1[l/2];
	end

	assign side_in = '{vld: vld_s1, pmiss: pmiss_s1, para: para_s1, neg: neg_l};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++) side_s2[k] <= '0;
		end else if (en) begin
			side_s2[0] <= side_in;
			for (int k = 1; k < DIV_LAT; k++) side_s2[k] <= side_s2[k-1];
		end
	end

	// stage 3: saturate and sign
	logic signed [DIST_W-1:0] t_s3 [6];
	side_t                    side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 6; l++) begin
				logic [REG_W-1:0] m;
				m = (ovf[l] || quo[l] > lim_q) ? lim_q : quo[l];
				t_s3[l] <= side_s2[DIV_LAT-1].neg[l] ? -{1'b0, m} : {1'b0, m};
			end
		end
	end

	// stage 4: order each slab
	logic signed [DIST_W-1:0] lo_s4 [3];
	logic signed [DIST_W-1:0] hi_s4 [3];
	logic                     pmiss_s4;
	logic signed [DIST_W-1:0] lim_s;
	assign lim_s = {1'b0, lim_q};

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				if (side_s3.para[a]) begin
					lo_s4[a] <= -lim_s;
					hi_s4[a] <= lim_s;
				end else if (t_s3[2*a] > t_s3[2*a+1]) begin
					lo_s4[a] <= t_s3[2*a+1];
					hi_s4[a] <= t_s3[2*a];
				end else begin
					lo_s4[a] <= t_s3[2*a];
					hi_s4[a] <= t_s3[2*a+1];
				end
			end
			pmiss_s4 <= side_s3.pmiss;
		end
	end

	// stage 5: entry and exit
	logic signed [DIST_W-1:0] entry_s5;
	logic signed [DIST_W-1:0] exit_s5;
	logic                     pmiss_s5;
	logic signed [DIST_W-1:0] e01, e2l, x01, x2l;

	always_comb begin
		e01 = (lo_s4[0] > lo_s4[1]) ? lo_s4[0] : lo_s4[1];
		e2l = (lo_s4[2] > -lim_s) ? lo_s4[2] : -lim_s;
		x01 = (hi_s4[0] < hi_s4[1]) ? hi_s4[0] : hi_s4[1];
		x2l = (hi_s4[2] < lim_s) ? hi_s4[2] : lim_s;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			entry_s5 <= (e01 > e2l) ? e01 : e2l;
			exit_s5  <= (x01 < x2l) ? x01 : x2l;
			pmiss_s5 <= pmiss_s4;
		end
	end

	logic vld_s3, vld_s4, vld_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3       <= '0;
			vld_s4        <= 1'b0;
			vld_s5        <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			side_s3       <= side_s2[DIV_LAT-1];
			vld_s4        <= vld_s3;
			vld_s5        <= vld_s4;
			m_axis_tvalid <= vld_s5;
		end
	end
	assign vld_s3 = side_s3.vld;

	// stage 6: hit decision into the output register
	logic miss, org_inside;
	assign miss       = pmiss_s5 || (exit_s5 < entry_s5) || (exit_s5 < 0);
	assign org_inside = !(entry_s5 > 0);

	always_ff @(posedge clk) begin
		if (en) begin
			if (miss) begin
				m_axis_tdata <= '0;
			end else begin
				m_axis_tdata <= {{(OUT_TDATA_W-DIST_W-2){1'b0}}, org_inside,
					org_inside ? exit_s5 : entry_s5, 1'b1};
			end
		end
	end

	`RBSI_ASSERT_SAME(a_miss_zero, clk, arst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[DIST_W+1:1] == '0, "miss result carries nonzero fields")
	`RBSI_ASSERT_SAME(a_entry_pos, clk, arst_n, m_axis_tvalid && m_axis_tdata[0] && !m_axis_tdata[DIST_W+1], !m_axis_tdata[DIST_W] && m_axis_tdata[DIST_W-1:1] != '0, "entry hit distance not positive")
	`RBSI_ASSERT_SAME(a_stall_cause, clk, arst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input held without output stall")
	`RBSI_ASSERT_NEXT(a_drain, clk, arst_n, m_axis_tvalid && m_axis_tready && !vld_s5, !m_axis_tvalid, "result appeared without a source")
endmodule
